// File: hw/rtl/cram_pkg.sv
// ----------------------------------------------------------------------------
// cram_pkg
// Shared widths for the 3x3 Cramer's rule solver.
// ----------------------------------------------------------------------------
package cram_pkg;
	localparam int SOL_W   = 49;
	localparam int NUM_IN  = 12;
	localparam int OUT_TW  = ((3 * SOL_W + 7) / 8) * 8;
endpackage

// File: hw/rtl/cram_det.sv
// ----------------------------------------------------------------------------
// cram_det
// Four-stage 3x3 determinant, expanded along the first row.
// ----------------------------------------------------------------------------
module cram_det import cram_pkg::*; #(
	parameter int W = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [W-1:0]   p0, p1, p2,
	input  logic signed [W-1:0]   q0, q1, q2,
	input  logic signed [W-1:0]   r0, r1, r2,
	output logic signed [3*W+2:0] det
);
	localparam int PW = 2 * W;
	localparam int CW = 2 * W + 1;
	localparam int TW = 3 * W + 1;
	localparam int DW = 3 * W + 3;

	logic signed [PW-1:0] m0_s1, m1_s1, m2_s1, m3_s1, m4_s1, m5_s1;
	logic signed [W-1:0]  p0_s1, p1_s1, p2_s1, p0_s2, p1_s2, p2_s2;
	logic signed [CW-1:0] c0_s2, c1_s2, c2_s2;
	logic signed [TW-1:0] t0_s3, t1_s3, t2_s3;
	logic signed [DW-1:0] det_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			m0_s1  <= q1 * r2;
			m1_s1  <= q2 * r1;
			m2_s1  <= q0 * r2;
			m3_s1  <= q2 * r0;
			m4_s1  <= q0 * r1;
			m5_s1  <= q1 * r0;
			p0_s1  <= p0;
			p1_s1  <= p1;
			p2_s1  <= p2;
			c0_s2  <= CW'(m0_s1) - CW'(m1_s1);
			c1_s2  <= CW'(m2_s1) - CW'(m3_s1);
			c2_s2  <= CW'(m4_s1) - CW'(m5_s1);
			p0_s2  <= p0_s1;
			p1_s2  <= p1_s1;
			p2_s2  <= p2_s1;
			t0_s3  <= p0_s2 * c0_s2;
			t1_s3  <= p1_s2 * c1_s2;
			t2_s3  <= p2_s2 * c2_s2;
			det_s4 <= DW'(t0_s3) - DW'(t1_s3) + DW'(t2_s3);
		end
	end

	assign det = det_s4;
endmodule

// File: hw/rtl/cram_div.sv
// ----------------------------------------------------------------------------
// cram_div
// Pipelined signed restoring divider, one quotient bit per stage,
// truncating toward zero; zero result for a zero divisor.
// ----------------------------------------------------------------------------
module cram_div import cram_pkg::*; #(
	parameter int DW = 51
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic signed [DW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic                 out_vld,
	output logic                 out_nz,
	output logic [SOL_W-1:0]     quo
);
	localparam int QW = (DW + 1 > SOL_W) ? DW + 1 : SOL_W;

	logic [DW-1:0] rem_s [0:DW];
	logic [DW-1:0] num_s [0:DW];
	logic [DW-1:0] den_s [0:DW];
	logic [DW-1:0] quo_s [0:DW];
	logic          neg_s [0:DW];
	logic          nz_s  [0:DW];
	logic          vld_s [0:DW];

	logic             vld_q, nz_q;
	logic [SOL_W-1:0] quo_q;
	logic signed [QW-1:0] qext, qsgn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= num[DW-1] ? DW'(-num) : DW'(num);
			den_s[0] <= den[DW-1] ? DW'(-den) : DW'(den);
			neg_s[0] <= num[DW-1] ^ den[DW-1];
			nz_s[0]  <= |den;
			rem_s[0] <= '0;
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < DW; k++) begin : g_stage
		localparam int B = DW - 1 - k;
		logic [DW:0] trial, diff;
		logic        ge;

		assign trial = {rem_s[k], num_s[k][B]};
		assign ge    = trial >= {1'b0, den_s[k]};
		assign diff  = trial - {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				quo_s[k+1] <= quo_s[k] | (DW'(ge) << B);
				num_s[k+1] <= num_s[k];
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				nz_s[k+1]  <= nz_s[k];
			end
		end
	end

	assign qext = QW'(quo_s[DW]);
	assign qsgn = neg_s[DW] ? -qext : qext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[DW];
		end
	end

	// zero the quotient of a singular system
	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= nz_s[DW] ? qsgn[SOL_W-1:0] : '0;
			nz_q  <= nz_s[DW];
		end
	end

	assign out_vld = vld_q;
	assign out_nz  = nz_q;
	assign quo     = quo_q;
endmodule

// File: hw/rtl/solve_3x3_linear_cramer.sv
// ----------------------------------------------------------------------------
// solve_3x3_linear_cramer
// Solves one 3x3 integer system per transfer by Cramer's rule.
// ----------------------------------------------------------------------------
// channel  dir  signals                    content
// s_*      in   s_tvalid s_tready s_tdata  a00..a22, rhs0..rhs2
// m_*      out  m_tvalid m_tready m_tdata  sol_x, sol_y, sol_z
//                          m_tuser         unique_res
//
// One system enters per cycle while s_tready is high and passes 4 determinant
// stages, 3*COEF_WIDTH+5 divider stages and the output register. arst_n clears
// all valid bits. A stall backs up through a skid register; s_tready is
// registered and drops only when the skid stage is full.
// ----------------------------------------------------------------------------
module solve_3x3_linear_cramer import cram_pkg::*; #(
	parameter int COEF_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// a00 a01 a02 a10 a11 a12 a20 a21 a22 rhs0 rhs1 rhs2, zero pad
	input  logic [((NUM_IN*COEF_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// sol_x sol_y sol_z, zero pad
	output logic [OUT_TW-1:0]       m_tdata,
	// unique_res
	output logic [0:0]              m_tuser
);
	localparam int W  = COEF_WIDTH;
	localparam int DW = 3 * W + 3;

	logic signed [W-1:0] f [0:NUM_IN-1];
	logic signed [DW-1:0] d, dx, dy, dz;
	logic v_s1, v_s2, v_s3, v_s4;
	logic en;
	logic vx, vy, vz, nzx, nzy, nzz;
	logic [SOL_W-1:0] qx, qy, qz;
	logic [OUT_TW-1:0] res_data;
	logic out_vld_q, skid_vld_q, out_usr_q, skid_usr_q;
	logic [OUT_TW-1:0] out_data_q, skid_data_q;

	for (genvar i = 0; i < NUM_IN; i++) begin : g_unpack
		assign f[i] = s_tdata[i*W +: W];
	end

	assign en       = ~skid_vld_q;
	assign s_tready = en;

	cram_det #(.W(W)) u_det_d (
		.clk(clk), .en(en),
		.p0(f[0]), .p1(f[1]), .p2(f[2]),
		.q0(f[3]), .q1(f[4]), .q2(f[5]),
		.r0(f[6]), .r1(f[7]), .r2(f[8]),
		.det(d)
	);
	cram_det #(.W(W)) u_det_x (
		.clk(clk), .en(en),
		.p0(f[9]),  .p1(f[1]), .p2(f[2]),
		.q0(f[10]), .q1(f[4]), .q2(f[5]),
		.r0(f[11]), .r1(f[7]), .r2(f[8]),
		.det(dx)
	);
	cram_det #(.W(W)) u_det_y (
		.clk(clk), .en(en),
		.p0(f[0]), .p1(f[9]),  .p2(f[2]),
		.q0(f[3]), .q1(f[10]), .q2(f[5]),
		.r0(f[6]), .r1(f[11]), .r2(f[8]),
		.det(dy)
	);
	cram_det #(.W(W)) u_det_z (
		.clk(clk), .en(en),
		.p0(f[0]), .p1(f[1]), .p2(f[9]),
		.q0(f[3]), .q1(f[4]), .q2(f[10]),
		.r0(f[6]), .r1(f[7]), .r2(f[11]),
		.det(dz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	cram_div #(.DW(DW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v_s4),
		.num(dx), .den(d), .out_vld(vx), .out_nz(nzx), .quo(qx)
	);
	cram_div #(.DW(DW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v_s4),
		.num(dy), .den(d), .out_vld(vy), .out_nz(nzy), .quo(qy)
	);
	cram_div #(.DW(DW)) u_div_z (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v_s4),
		.num(dz), .den(d), .out_vld(vz), .out_nz(nzz), .quo(qz)
	);

	assign res_data = OUT_TW'({qz, qy, qx});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			out_vld_q  <= skid_vld_q | vx;
			skid_vld_q <= 1'b0;
		end else if (vx && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	// hold the pipeline result in the skid stage while the output stalls
	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			out_data_q <= skid_vld_q ? skid_data_q : res_data;
			out_usr_q  <= skid_vld_q ? skid_usr_q  : nzx;
		end else if (en) begin
			skid_data_q <= res_data;
			skid_usr_q  <= nzx;
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_usr_q;

	a_skid_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q) else $error("skid full with empty output");
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(vx == vy) && (vx == vz) && (!vx || ((nzx == nzy) && (nzx == nzz))))
		else $error("divider lanes out of step");
	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("singular system with nonzero solution");
endmodule

// File: tb/solve_3x3_linear_cramer_tb.sv
// ----------------------------------------------------------------------------
// solve_3x3_linear_cramer_tb
// Streams 3x3 integer systems into the solver and checks each solution
// against a predictor that computes the determinants at full width.
// ----------------------------------------------------------------------------
module solve_3x3_linear_cramer_tb;
	import cram_pkg::*;

	localparam int CW      = 16;
	localparam int IN_TW   = ((NUM_IN * CW + 7) / 8) * 8;
	localparam int LATENCY = 4 + 3 * CW + 5 + 1;
	localparam int WDOG    = 20000;

	typedef struct packed {
		logic [SOL_W-1:0] x;
		logic [SOL_W-1:0] y;
		logic [SOL_W-1:0] z;
		logic             uniq;
	} solution_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_TW-1:0] s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_TW-1:0] m_tdata;
	logic [0:0]       m_tuser;

	solution_t solution_q[$];
	int        mismatches;
	int        systems_sent;
	int        singular_sent;
	int        solutions_seen;
	int        idle_cycles;
	bit        hold_off;
	bit        done;

	solve_3x3_linear_cramer #(.COEF_WIDTH(CW)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic longint coef(input logic [IN_TW-1:0] d, input int idx);
		logic signed [CW-1:0] v;
		v = d[idx*CW +: CW];
		return longint'(v);
	endfunction

	function automatic longint det3(input longint p0, p1, p2, q0, q1, q2, r0, r1, r2);
		return p0 * (q1 * r2 - q2 * r1) - p1 * (q0 * r2 - q2 * r0)
			+ p2 * (q0 * r1 - q1 * r0);
	endfunction

	function automatic solution_t solve_system(input logic [IN_TW-1:0] d);
		longint    m[9];
		longint    b[3];
		longint    dm, dx, dy, dz;
		solution_t s;
		for (int i = 0; i < 9; i++)
			m[i] = coef(d, i);
		for (int i = 0; i < 3; i++)
			b[i] = coef(d, 9 + i);
		dm = det3(m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]);
		dx = det3(b[0], m[1], m[2], b[1], m[4], m[5], b[2], m[7], m[8]);
		dy = det3(m[0], b[0], m[2], m[3], b[1], m[5], m[6], b[2], m[8]);
		dz = det3(m[0], m[1], b[0], m[3], m[4], b[1], m[6], m[7], b[2]);
		s = '0;
		if (dm != 0) begin
			s.x = SOL_W'(dx / dm);
			s.y = SOL_W'(dy / dm);
			s.z = SOL_W'(dz / dm);
			s.uniq = 1'b1;
		end
		return s;
	endfunction

	// Offer one system and wait for its transfer.
	task automatic send_system(input logic [IN_TW-1:0] d);
		s_tdata  <= d;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		solution_q.push_back(solve_system(d));
		systems_sent++;
		if (solve_system(d).uniq == 1'b0)
			singular_sent++;
		@(negedge clk);
	endtask

	task automatic pause_sender(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	function automatic logic [IN_TW-1:0] pack_fields(input logic [CW-1:0] f[12]);
		logic [IN_TW-1:0] d;
		d = '0;
		for (int i = 0; i < 12; i++)
			d[i*CW +: CW] = f[i];
		return d;
	endfunction

	function automatic logic [CW-1:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return {1'b1, {(CW-1){1'b0}}};
			1: return {1'b0, {(CW-1){1'b1}}};
			2: return CW'($urandom_range(0, 6)) - CW'(3);
			3: return CW'($urandom_range(0, 200)) - CW'(100);
			default: return CW'($urandom);
		endcase
	endfunction

	task automatic test_extremes();
		logic [CW-1:0] f[12];
		logic [CW-1:0] vals[4];
		vals = '{{1'b1, {(CW-1){1'b0}}}, {1'b0, {(CW-1){1'b1}}}, '1, '0};
		foreach (vals[k]) begin
			foreach (f[i]) f[i] = vals[k];
			send_system(pack_fields(f));
		end
		// alternate min and max over the fields; rows 0 and 2 match, so this system is singular
		foreach (f[i]) f[i] = (i % 2) ? vals[0] : vals[1];
		send_system(pack_fields(f));
		f = '{vals[0], vals[1], vals[1], vals[1], vals[0], vals[1], vals[1], vals[1],
			vals[0], vals[1], vals[0], vals[1]};
		send_system(pack_fields(f));
	endtask

	task automatic test_identity_and_singular();
		logic [CW-1:0] f[12];
		f = '{1, 0, 0, 0, 1, 0, 0, 0, 1, 5, -7, 32767};
		send_system(pack_fields(f));
		f = '{2, 0, 0, 0, 3, 0, 0, 0, -4, 7, -7, 9};
		send_system(pack_fields(f));
		f = '{-1, 0, 0, 0, -1, 0, 0, 0, -1, -32768, 32767, 1};
		send_system(pack_fields(f));
		// dependent rows: singular
		f = '{1, 2, 3, 2, 4, 6, 5, 1, 9, 1, 2, 3};
		send_system(pack_fields(f));
		f = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12};
		send_system(pack_fields(f));
		f = '{0, 0, 0, 1, 2, 3, 4, 5, 6, -1, -1, -1};
		send_system(pack_fields(f));
		f = '{1, 1, 1, 1, 1, 1, 1, 1, 2, 3, 3, 3};
		send_system(pack_fields(f));
		f = '{3, 1, 1, 1, 3, 1, 1, 1, 3, -1, 1, -2};
		send_system(pack_fields(f));
	endtask

	task automatic test_random(input int n);
		logic [CW-1:0] f[12];
		int burst;
		int sent;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
			for (int k = 0; k < burst && sent < n; k++) begin
				foreach (f[i]) f[i] = rand_coef();
				// make one in five singular on average by copying row 0 into row 2
				if ($urandom_range(0, 4) == 0) begin
					f[6] = f[0]; f[7] = f[1]; f[8] = f[2];
				end
				send_system(pack_fields(f));
				sent++;
			end
			if ($urandom_range(0, 2) != 0)
				pause_sender($urandom_range(1, 6));
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic test_backpressure();
		logic [CW-1:0] f[12];
		hold_off = 1'b1;
		for (int k = 0; k < 100; k++) begin
			foreach (f[i]) f[i] = rand_coef();
			send_system(pack_fields(f));
		end
		pause_sender(1);
	endtask

	// Receiver: random stall pattern, plus a long hold-off on request.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			case ($urandom_range(0, 3))
				0: m_tready <= 1'b0;
				1: m_tready <= ($urandom_range(0, 1) == 1);
				default: m_tready <= 1'b1;
			endcase
		end
	end

	// Check each transfer against the oldest predicted solution.
	always @(posedge clk) begin
		solution_t want;
		solution_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[0 +: SOL_W], m_tdata[SOL_W +: SOL_W], m_tdata[2*SOL_W +: SOL_W],
				m_tuser[0]};
			solutions_seen++;
			if (solution_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: %h", got);
			end else begin
				want = solution_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected x=%h y=%h z=%h u=%b, got x=%h y=%h z=%h u=%b",
							want.x, want.y, want.z, want.uniq, got.x, got.y, got.z, got.uniq);
				end
			end
		end
	end

	// Watchdog: end the run after a long stretch with no transfer.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WDOG && !done) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		arst_n       = 1'b0;
		mismatches   = 0;
		systems_sent = 0;
		singular_sent = 0;
		solutions_seen = 0;
		idle_cycles  = 0;
		hold_off     = 1'b0;
		done         = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_identity_and_singular();
		test_backpressure();
		test_random(800);
		while (solution_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		done = 1'b1;
		$display("Ran %0d systems (%0d singular), %0d solutions checked, %0d mismatches.",
			systems_sent, singular_sent, solutions_seen, mismatches);
		if (mismatches == 0 && solution_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// File: solve_3x3_linear_cramer.f
hw/rtl/cram_pkg.sv
hw/rtl/cram_det.sv
hw/rtl/cram_div.sv
hw/rtl/solve_3x3_linear_cramer.sv
tb/solve_3x3_linear_cramer_tb.sv
